// ===== rtl/core/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// PID core package
// Shared widths, register indexes, the divider request and response
// structs, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pfd_pkg;

	// Common data widths.
	localparam int DATA_W = 32;
	localparam int PAR_W  = 31;
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SAT_W  = 52;

	// Shared divider sizing: remainder and divisor, dividend bits and step count.
	localparam int REM_W  = 33;
	localparam int DVD_W  = 50;
	localparam int STEP_W = 6;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_DERIV_TAU   = 3'd3,
		REG_SAMPLE_PER  = 3'd4,
		REG_OUT_LOW     = 3'd5,
		REG_OUT_HIGH    = 3'd6
	} cfg_reg_t;

	// Request to the shared divider.
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [REM_W-1:0]  rem_init;
		logic [DVD_W-1:0]  dividend;
		logic [REM_W-1:0]  divisor;
	} div_req_t;

	// Status and result of the shared divider.
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[SAT_W-1:DATA_W-1];
		all_zeros = ~|v[SAT_W-1:DATA_W-1];
		if (all_ones || all_zeros)
			return v[DATA_W-1:0];
		else if (v[SAT_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

endpackage

// ===== rtl/core/pfd_mul.sv =====
// ----------------------------------------------------------------------------
// PID core shared multiplier
// Signed multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module pfd_mul import pfd_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod
);

	// The product is available in the cycle after the operands.
	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end

endmodule

// ===== rtl/core/pfd_div.sv =====
// ----------------------------------------------------------------------------
// PID core shared divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfd_div import pfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [REM_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [REM_W-1:0]  div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    trial_sub;
	logic              fits;

	// One trial subtraction of the shifted remainder.
	always_comb begin
		trial     = {rem_q, dvd_q[DVD_W-1]};
		trial_sub = trial - {1'b0, div_q};
		fits      = (trial >= {1'b0, div_q});
	end

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/core/pid_filtered_derivative_antiwindup_core.sv =====
// ----------------------------------------------------------------------------
// PID controller core
// Q16.16 PID with a band-limited derivative, trapezoidal integrator and
// back-calculation anti-windup, built around one multiplier and one divider.
// ----------------------------------------------------------------------------
// The time from a sample's input transfer to its result is set mostly by the
// bit-serial divider, with 31 steps for the derivative pole, 50 for the
// derivative input gain and 41 for the anti-windup correction. With a zero
// filter denominator the two derivative divisions are skipped, and with a
// zero integral gain the correction is skipped. A new sample is taken only
// while the core is idle; a finished result waits in the output register
// without stopping the next input transfer.
module pid_filtered_derivative_antiwindup_core import pfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream: tdata holds setpoint [31:0], measurement [63:32].
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,
	// Output stream: tdata holds drive [31:0].
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	typedef enum logic [17:0] {
		ST_IDLE  = 18'h00001,
		ST_PREP  = 18'h00002,
		ST_INTEG = 18'h00004,
		ST_DIVA  = 18'h00008,
		ST_DIVB  = 18'h00010,
		ST_MULD  = 18'h00020,
		ST_UPDD  = 18'h00040,
		ST_MKP   = 18'h00080,
		ST_MKD   = 18'h00100,
		ST_MKI   = 18'h00200,
		ST_SUMI  = 18'h00400,
		ST_CLAMP = 18'h00800,
		ST_CM0   = 18'h01000,
		ST_CM1   = 18'h02000,
		ST_CM2   = 18'h04000,
		ST_CDIV  = 18'h08000,
		ST_CWAIT = 18'h10000,
		ST_OUT   = 18'h20000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, lo_q, hi_q;
	logic [PAR_W-1:0]         tau_q, ts_q;

	// Controller state and working registers.
	logic signed [DATA_W-1:0] e_q, pe_q, d_q, i_q, a_q, res_q;
	logic signed [32:0]       diff_q;
	logic signed [50:0]       bterm_q;
	logic signed [49:0]       u_q;
	logic [50:0]              mag_q;
	logic                     neg_q;
	logic [62:0]              plo_q;
	logic [81:0]              p_q;
	logic [DATA_W-1:0]        m_tdata_q;
	logic                     m_tvalid_q;

	// Shared units.
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	// Derived values.
	logic [32:0]              den_w;
	logic signed [32:0]       num_w;
	logic [32:0]              num_mag;
	logic [32:0]              diff_mag;
	logic [31:0]              ki_mag;
	logic signed [32:0]       err_w;
	logic signed [50:0]       excess_w;
	logic signed [DATA_W-1:0] res_w;
	logic                     corr_ovf;
	logic                     q_ovf;
	logic [40:0]              corr_mag;
	logic signed [42:0]       corr_w;
	logic                     in_xfer;
	logic                     out_free;

	pfd_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	pfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Filter denominator and numerator, magnitudes for the divider.
	always_comb begin
		den_w    = {1'b0, tau_q, 1'b0} + {2'b0, ts_q};
		num_w    = $signed({1'b0, tau_q, 1'b0}) - $signed({2'b0, ts_q});
		num_mag  = num_w[32] ? 33'(-num_w) : 33'(num_w);
		diff_mag = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
		ki_mag   = ki_q[31] ? 32'(-ki_q) : 32'(ki_q);
		err_w    = 33'($signed(s_tdata[31:0])) - 33'($signed(s_tdata[63:32]));
	end

	// Output clamp; the high limit is tested first.
	always_comb begin
		if (u_q > 50'(hi_q))
			res_w = hi_q;
		else if (u_q < 50'(lo_q))
			res_w = lo_q;
		else
			res_w = u_q[DATA_W-1:0];
		excess_w = 51'(res_w) - 51'(u_q);
	end

	// Anti-windup correction with its magnitude held to 2^40.
	always_comb begin
		corr_ovf = (p_q[81:41] >= {9'b0, ki_mag});
		q_ovf    = div_rsp.quotient[40] && (|div_rsp.quotient[39:0]);
		if (state_q == ST_CDIV || q_ovf)
			corr_mag = {1'b1, 40'b0};
		else
			corr_mag = div_rsp.quotient[40:0];
		corr_w = neg_q ? -43'($signed({1'b0, corr_mag})) : 43'($signed({1'b0, corr_mag}));
	end

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PREP: begin
				mul_a = $signed({3'b0, ts_q});
				mul_b = 34'(e_q) + 34'(pe_q);
			end
			ST_MULD: begin
				mul_a = 34'(a_q);
				mul_b = 34'(d_q);
			end
			ST_MKP: begin
				mul_a = 34'(kp_q);
				mul_b = 34'(e_q);
			end
			ST_MKD: begin
				mul_a = 34'(kd_q);
				mul_b = 34'(d_q);
			end
			ST_MKI: begin
				mul_a = 34'(ki_q);
				mul_b = 34'(i_q);
			end
			ST_CM0: begin
				mul_a = $signed({3'b0, ts_q});
				mul_b = $signed({2'b0, mag_q[31:0]});
			end
			ST_CM1: begin
				mul_a = $signed({3'b0, ts_q});
				mul_b = $signed({15'b0, mag_q[50:32]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Divider requests for the three divisions.
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_INTEG: begin
				div_req.start    = (den_w != '0);
				div_req.steps    = STEP_W'(31);
				div_req.rem_init = {1'b0, num_mag[32:1]};
				div_req.dividend = {num_mag[0], 49'b0};
				div_req.divisor  = den_w;
			end
			ST_DIVA: begin
				div_req.start    = div_rsp.done;
				div_req.steps    = STEP_W'(50);
				div_req.rem_init = '0;
				div_req.dividend = {diff_mag, 17'b0};
				div_req.divisor  = den_w;
			end
			ST_CDIV: begin
				div_req.start    = !corr_ovf;
				div_req.steps    = STEP_W'(41);
				div_req.rem_init = {1'b0, p_q[72:41]};
				div_req.dividend = {p_q[40:0], 9'b0};
				div_req.divisor  = {1'b0, ki_mag};
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= '0;
			ki_q  <= '0;
			kd_q  <= '0;
			tau_q <= PAR_W'(3277);
			ts_q  <= PAR_W'(655);
			lo_q  <= {1'b1, {(DATA_W-1){1'b0}}};
			hi_q  <= {1'b0, {(DATA_W-1){1'b1}}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:  kp_q  <= cfg_data;
				REG_INTEG_GAIN: ki_q  <= cfg_data;
				REG_DERIV_GAIN: kd_q  <= cfg_data;
				REG_DERIV_TAU:  tau_q <= cfg_data[PAR_W-1:0];
				REG_SAMPLE_PER: ts_q  <= cfg_data[PAR_W-1:0];
				REG_OUT_LOW:    lo_q  <= cfg_data;
				REG_OUT_HIGH:   hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output valid flag: set when a sample is handed over, cleared by the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Sequencer and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			d_q        <= '0;
			i_q        <= '0;
			pe_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						e_q     <= sat32(SAT_W'(err_w));
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_INTEG;
				end
				ST_INTEG: begin
					i_q    <= sat32(SAT_W'(i_q) + SAT_W'(prod >>> 17));
					pe_q   <= e_q;
					diff_q <= 33'(e_q) - 33'(pe_q);
					if (den_w == '0) begin
						d_q     <= '0;
						state_q <= ST_MKP;
					end else begin
						state_q <= ST_DIVA;
					end
				end
				ST_DIVA: begin
					if (div_rsp.done) begin
						a_q     <= num_w[32] ? -32'($signed({1'b0, div_rsp.quotient[30:0]}))
						                     :  32'($signed({1'b0, div_rsp.quotient[30:0]}));
						state_q <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					if (div_rsp.done) begin
						bterm_q <= diff_q[32] ? -51'($signed({1'b0, div_rsp.quotient}))
						                      :  51'($signed({1'b0, div_rsp.quotient}));
						state_q <= ST_MULD;
					end
				end
				ST_MULD: begin
					state_q <= ST_UPDD;
				end
				ST_UPDD: begin
					d_q     <= sat32(SAT_W'(prod >>> 30) + SAT_W'(bterm_q));
					state_q <= ST_MKP;
				end
				ST_MKP: begin
					state_q <= ST_MKD;
				end
				ST_MKD: begin
					u_q     <= prod[65:16];
					state_q <= ST_MKI;
				end
				ST_MKI: begin
					u_q     <= u_q + prod[65:16];
					state_q <= ST_SUMI;
				end
				ST_SUMI: begin
					u_q     <= u_q + prod[65:16];
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					res_q   <= res_w;
					mag_q   <= excess_w[50] ? 51'(-excess_w) : 51'(excess_w);
					neg_q   <= excess_w[50] ^ ki_q[31];
					state_q <= (ki_q != '0) ? ST_CM0 : ST_OUT;
				end
				ST_CM0: begin
					state_q <= ST_CM1;
				end
				ST_CM1: begin
					plo_q   <= prod[62:0];
					state_q <= ST_CM2;
				end
				ST_CM2: begin
					p_q     <= {prod[49:0], 32'b0} + {19'b0, plo_q};
					state_q <= ST_CDIV;
				end
				ST_CDIV: begin
					if (corr_ovf) begin
						i_q     <= sat32(SAT_W'(i_q) + SAT_W'(corr_w));
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_CWAIT;
					end
				end
				ST_CWAIT: begin
					if (div_rsp.done) begin
						i_q     <= sat32(SAT_W'(i_q) + SAT_W'(corr_w));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tdata_q  <= res_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The divider finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVA || state_q == ST_DIVB || state_q == ST_CWAIT))
		else $error("divider result arrived outside a wait state");

	// A division is never started on top of one still running.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// An input transfer always begins a new sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_PREP))
		else $error("input transfer did not start a sample");
`endif

endmodule
